// ===== rtl/csf_pkg.sv =====
// Package for the circular sample FIFO: sizes, operation and status codes,
// and the packed item and result types. No dependencies.
package csf_pkg;

    localparam int DEPTH      = 256;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH) + 1;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    // The remaining code changes nothing and reports the current state.
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;
    localparam logic [1:0] ST_CLEARED    = 2'd3;

    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);

    typedef struct packed {
        logic [1:0]            func;
        logic [WORD_WIDTH-1:0] push_word;
    } t_item;

    typedef struct packed {
        logic [1:0]            status;
        logic [WORD_WIDTH-1:0] front_word;
        logic                  front_valid;
        logic [CNT_W-1:0]      fill_count;
        logic                  is_empty;
        logic                  is_full;
    } t_result;

endpackage

// ===== rtl/csf_ram.sv =====
// Sample store of the circular FIFO: one write port, one read port with
// registered read data. Depends on csf_pkg.
module csf_ram (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [csf_pkg::ADDR_W-1:0]     i_waddr,
    input  logic [csf_pkg::WORD_WIDTH-1:0] i_wdata,
    input  logic                           i_re,
    input  logic [csf_pkg::ADDR_W-1:0]     i_raddr,
    output logic [csf_pkg::WORD_WIDTH-1:0] o_rdata
);
    import csf_pkg::*;

    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read returns the old contents on a same-address write; the caller forwards.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/circular_sample_fifo_top.sv =====
// Top level of the circular sample FIFO: head/count control, capacity
// register and result register. Depends on csf_pkg and csf_ram.
//
//  channel   | signals                 | handshake
//  ----------+-------------------------+------------------------------------
//  command   | start, busy, i_item     | taken when start high, busy, cfg_we low
//  result    | o_done, o_result        | o_done high for one cycle per item
//  config    | i_cfg_we, i_cfg_data    | capacity written when i_cfg_we high
//
// For each transaction the store is written and the new head read at the
// accept edge, and the result appears in the next cycle, so a command can be
// given every cycle (busy stays low). The result waits on the registered
// read of the sample store. Reset is synchronous and empties the buffer with
// capacity zero; the store itself is not cleared.
// The receiver cannot stall the result.
module circular_sample_fifo_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  csf_pkg::t_item   i_item,
    output logic             o_done,
    output csf_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [8:0]       i_cfg_data
);
    import csf_pkg::*;

    logic [CNT_W-1:0]      r_cap, n_cap;
    logic [ADDR_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_done;
    logic [1:0]            r_status, n_status;
    logic                  r_fwd, n_fwd;
    logic [WORD_WIDTH-1:0] r_fwd_word;
    logic                  r_full;

    logic                  accept;
    logic [CNT_W-1:0]      head_ext;
    logic [CNT_W-1:0]      tail_sum;
    logic [CNT_W-1:0]      tail_idx;
    logic [CNT_W-1:0]      head_inc;
    logic                  push_ok;
    logic                  pop_ok;
    logic                  wr_en;
    logic [WORD_WIDTH-1:0] rd_data;
    logic                  front_valid;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign head_ext = {1'b0, r_head};
    // Head and count are both below or at the capacity, so one subtract wraps.
    assign tail_sum = head_ext + r_count;
    assign tail_idx = (tail_sum >= r_cap) ? (tail_sum - r_cap) : tail_sum;
    assign head_inc = head_ext + CNT_W'(1);
    assign push_ok  = (r_count < r_cap);
    assign pop_ok   = (r_count != '0);
    assign wr_en    = accept && (i_item.func == FUNC_PUSH) && push_ok;

    always_comb begin
        n_cap    = r_cap;
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        n_fwd    = 1'b0;
        if (i_cfg_we) begin
            n_cap   = (i_cfg_data > CAP_MAX) ? CAP_MAX : CNT_W'(i_cfg_data);
            n_head  = '0;
            n_count = '0;
        end else if (accept) begin
            case (i_item.func)
                FUNC_PUSH: begin
                    if (push_ok) begin
                        n_count = r_count + CNT_W'(1);
                        // Pushing into an empty buffer makes the new word the front.
                        n_fwd   = !pop_ok;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                FUNC_POP: begin
                    if (pop_ok) begin
                        n_head  = (head_inc >= r_cap) ? '0 : head_inc[ADDR_W-1:0];
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
                FUNC_CLEAR: begin
                    n_status = pop_ok ? ST_CLEARED : ST_OK;
                    n_head   = '0;
                    n_count  = '0;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_status <= ST_OK;
            r_fwd    <= 1'b0;
            r_full   <= 1'b0;
        end else begin
            r_cap    <= n_cap;
            r_head   <= n_head;
            r_count  <= n_count;
            r_done   <= accept && !i_cfg_we;
            r_status <= n_status;
            r_fwd    <= n_fwd;
            r_full   <= (n_count >= n_cap);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_word <= i_item.push_word;
    end

    csf_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (tail_idx[ADDR_W-1:0]),
        .i_wdata (i_item.push_word),
        .i_re    (accept),
        .i_raddr (n_head),
        .o_rdata (rd_data)
    );

    assign front_valid = (r_count != '0);

    assign o_done               = r_done;
    assign o_result.status      = r_status;
    assign o_result.front_word  = front_valid ? (r_fwd ? r_fwd_word : rd_data) : '0;
    assign o_result.front_valid = front_valid;
    assign o_result.fill_count  = r_count;
    assign o_result.is_empty    = !front_valid;
    assign o_result.is_full     = r_full;

endmodule

// ===== sim/csf_monitor.sv =====
`timescale 1ns / 100ps
// Monitor for the circular sample FIFO: keeps its own copy of the ring buffer,
// works out each result from the commands taken and compares. Needs csf_pkg.
module csf_monitor (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  csf_pkg::t_item   i_item,
    input  logic             i_done,
    input  csf_pkg::t_result i_result,
    input  logic             i_cfg_we,
    input  logic [8:0]       i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    import csf_pkg::*;

    logic [WORD_WIDTH-1:0] ring_words [DEPTH];
    logic [CNT_W-1:0]      ring_head;
    logic [CNT_W-1:0]      ring_fill;
    logic [CNT_W-1:0]      ring_cap;
    t_result               awaited_results [$];

    task automatic note_mismatch(input string what, input longint got, input longint want);
        o_fail_count++;
        $display("%0t: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    // Applies one command to the ring copy and returns the result it causes.
    function automatic t_result apply_command(input t_item cmd);
        t_result          res;
        logic [CNT_W-1:0] tail;
        res = '0;
        res.status = ST_OK;
        case (cmd.func)
            FUNC_PUSH: begin
                if (ring_fill >= ring_cap) begin
                    res.status = ST_FULL;
                end else begin
                    tail = ring_head + ring_fill;
                    if (tail >= ring_cap)
                        tail = tail - ring_cap;
                    ring_words[tail[ADDR_W-1:0]] = cmd.push_word;
                    ring_fill = ring_fill + 1'b1;
                end
            end
            FUNC_POP: begin
                if (ring_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    ring_head = (ring_head + 1'b1 >= ring_cap) ? '0 : ring_head + 1'b1;
                    ring_fill = ring_fill - 1'b1;
                end
            end
            FUNC_CLEAR: begin
                res.status = (ring_fill != 0) ? ST_CLEARED : ST_OK;
                ring_head  = '0;
                ring_fill  = '0;
            end
            default: ;
        endcase
        if (ring_fill != 0) begin
            res.front_word  = ring_words[ring_head[ADDR_W-1:0]];
            res.front_valid = 1'b1;
        end
        res.fill_count = ring_fill;
        res.is_empty   = (ring_fill == 0);
        res.is_full    = (ring_fill >= ring_cap);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ring_head = '0;
            ring_fill = '0;
            ring_cap  = '0;
            awaited_results.delete();
        end else begin
            if (i_done === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    note_mismatch("result with no transaction outstanding", 1, 0);
                end else begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    o_checked++;
                    if (i_result.status !== want.status)
                        note_mismatch("status", longint'(i_result.status),
                                      longint'(want.status));
                    if (i_result.front_word !== want.front_word)
                        note_mismatch("front_word", longint'(i_result.front_word),
                                      longint'(want.front_word));
                    if (i_result.front_valid !== want.front_valid)
                        note_mismatch("front_valid", longint'(i_result.front_valid),
                                      longint'(want.front_valid));
                    if (i_result.fill_count !== want.fill_count)
                        note_mismatch("fill_count", longint'(i_result.fill_count),
                                      longint'(want.fill_count));
                    if (i_result.is_empty !== want.is_empty)
                        note_mismatch("is_empty", longint'(i_result.is_empty),
                                      longint'(want.is_empty));
                    if (i_result.is_full !== want.is_full)
                        note_mismatch("is_full", longint'(i_result.is_full),
                                      longint'(want.is_full));
                end
            end
            // A capacity write empties the buffer; values above the store size saturate.
            if (i_cfg_we) begin
                ring_cap  = (i_cfg_data > CAP_MAX) ? CAP_MAX : i_cfg_data;
                ring_head = '0;
                ring_fill = '0;
            end
            if (i_start && !i_busy)
                awaited_results.insert(awaited_results.size(), apply_command(i_item));
        end
        o_pending = awaited_results.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top of the circular sample FIFO testbench: clock, reset, command and
// capacity stimulus, and the verdict. Needs csf_pkg, csf_monitor and the RTL.
module testbench;
    import csf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_item       i_item     = '0;
    logic        o_done;
    t_result     o_result;
    logic        i_cfg_we   = 1'b0;
    logic [8:0]  i_cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int commands_sent = 0;
    int cap_settings  = 0;

    always #4 i_clk = ~i_clk;

    circular_sample_fifo_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    csf_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Drives one command and returns at the edge that takes it.
    task automatic send_command(input logic [1:0] func, input logic [WORD_WIDTH-1:0] word,
                                input bit idle_ok);
        t_item cmd;
        cmd.func      = func;
        cmd.push_word = word;
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        commands_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [8:0] cap);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_settings++;
    endtask

    function automatic logic [WORD_WIDTH-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // Random mix of commands; whatever is left after push, pop and clear is
    // the no-op function code.
    task automatic run_mix(input int count, input int push_pct, input int pop_pct,
                           input int clear_pct, input bit idle_ok);
        int          r;
        logic [1:0]  func;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                func = FUNC_PUSH;
            else if (r < push_pct + pop_pct)
                func = FUNC_POP;
            else if (r < push_pct + pop_pct + clear_pct)
                func = FUNC_CLEAR;
            else
                func = FUNC_NOP;
            send_command(func, pick_word(), idle_ok);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Capacity zero out of reset: nothing can be stored.
        send_command(FUNC_PUSH, 32'h1234_5678, 1'b0);
        send_command(FUNC_POP, '0, 1'b0);
        send_command(FUNC_CLEAR, '0, 1'b0);
        send_command(FUNC_NOP, '1, 1'b0);

        // Small ring: fill, refuse, wrap the tail, pop, then clear and pop when empty.
        set_capacity(9'd4);
        send_command(FUNC_PUSH, 32'h0000_0000, 1'b0);
        send_command(FUNC_PUSH, 32'hFFFF_FFFF, 1'b0);
        send_command(FUNC_PUSH, 32'hA5A5_A5A5, 1'b0);
        send_command(FUNC_PUSH, 32'h5A5A_5A5A, 1'b0);
        send_command(FUNC_PUSH, 32'hDEAD_BEEF, 1'b0);
        send_command(FUNC_POP, '0, 1'b0);
        send_command(FUNC_PUSH, 32'h8000_0001, 1'b0);
        send_command(FUNC_NOP, 32'h7FFF_FFFE, 1'b0);
        send_command(FUNC_POP, '0, 1'b0);
        send_command(FUNC_POP, '0, 1'b0);
        send_command(FUNC_CLEAR, '0, 1'b0);
        send_command(FUNC_CLEAR, '0, 1'b0);
        send_command(FUNC_POP, '0, 1'b0);

        set_capacity(9'd1);
        run_mix(40, 50, 40, 5, 1'b1);
        set_capacity(9'd2);
        run_mix(40, 50, 40, 5, 1'b1);
        set_capacity(9'd3);
        run_mix(50, 55, 35, 5, 1'b1);
        // Above the store size: the ring saturates at full depth; push until full.
        set_capacity(9'd511);
        run_mix(290, 98, 2, 0, 1'b1);
        run_mix(40, 20, 75, 3, 1'b0);
        set_capacity(9'd0);
        run_mix(20, 40, 40, 10, 1'b1);
        set_capacity(9'd256);
        run_mix(40, 60, 30, 5, 1'b1);
        set_capacity(9'd300);
        run_mix(20, 50, 40, 5, 1'b0);
        set_capacity(9'd16);
        run_mix(60, 55, 38, 4, 1'b1);
        set_capacity(9'd5);
        run_mix(50, 50, 40, 5, 1'b0);

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Ran %0d commands with %0d results compared over %0d capacity settings,",
                 commands_sent, checked, cap_settings);
        $display("from zero through full depth and above, with wrap, refusals and clears.");
        if (fail_count == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 CYCLE_LIMIT, pending);
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/csf_pkg.sv
rtl/csf_ram.sv
rtl/circular_sample_fifo_top.sv
sim/csf_monitor.sv
sim/testbench.sv
